>>> hw/rtl/tcw_pkg.sv
// text console writer package: request and result word types, request codes,
// color and control-character constants, and the controller state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// default screen geometry
	localparam int unsigned NUM_COLS_DEF = 80;
	localparam int unsigned NUM_ROWS_DEF = 24;

	// field widths, sized for the largest screen
	localparam int unsigned ROW_W  = 5;
	localparam int unsigned COL_W  = 7;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ATTR_W = 4;

	// request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// color cycle and control characters
	localparam logic [ATTR_W-1:0] COLOR_FIRST = 4'd9;
	localparam logic [ATTR_W-1:0] COLOR_LAST  = 4'hF;
	localparam logic [CHAR_W-1:0] CHAR_LF     = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  cell_row;
		logic [COL_W-1:0]  cell_col;
	} tcw_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attr;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [ATTR_W-1:0] current_color;
	} tcw_rsp_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_WAIT
	} tcw_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Text console writer. A put request writes the byte at the cursor with the current color
// and advances the cursor; line feed and carriage return are not written. Each of them, or
// the end of a row, starts a new line, which steps the color through 9..15. Put, clear and
// unused requests have their result word registered in the cycle after they are accepted, so
// puts stream at one word per cycle while result words are taken and no clearing pass runs.
// A read request waits in ST_RD_WAIT for the registered read data of the cell memory. The
// screen lives in one memory of NUM_ROWS*NUM_COLS cells used as a ring of rows, so a scroll
// only moves the top-row pointer, then zeroes the recycled row while blocking requests.
// A clear request zeroes all cells (1920 by default), blocking requests; reset runs it too.
// depends on tcw_pkg, tcw_ram
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
	parameter int unsigned NUM_COLS = tcw_pkg::NUM_COLS_DEF,
	parameter int unsigned NUM_ROWS = tcw_pkg::NUM_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  tcw_pkg::tcw_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output tcw_pkg::tcw_rsp_t rsp
);

	import tcw_pkg::*;

	localparam int unsigned CELLS  = NUM_COLS * NUM_ROWS;
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned DATA_W = CHAR_W + ATTR_W;
	localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(NUM_COLS);

	tcw_state_t state_q, state_d;

	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [ATTR_W-1:0] color_q, color_d;
	logic [ROW_W-1:0]  top_q, top_d;
	logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
	logic [ADDR_W-1:0] sweep_last_q, sweep_last_d;
	logic              rd_ok_s1;
	logic              rsp_valid_q;
	tcw_rsp_t          rsp_data_q;
	tcw_rsp_t          rsp_next;
	logic              rsp_load;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic              accept;
	logic              is_nl;
	logic              at_row_end;
	logic              at_last_row;
	logic              rd_in_range;
	logic [ATTR_W-1:0] color_step;
	logic [ROW_W-1:0]  top_step;
	logic [ADDR_W-1:0] scroll_base;

	// physical cell address of a screen row and column through the row ring
	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c,
		input logic [ROW_W-1:0] t
	);
		logic [ROW_W:0] sum;
		logic [ROW_W:0] phys;
		sum  = {1'b0, r} + {1'b0, t};
		phys = (sum >= (ROW_W + 1)'(NUM_ROWS)) ? sum - (ROW_W + 1)'(NUM_ROWS) : sum;
		return ADDR_W'(phys) * COLS_A + ADDR_W'(c);
	endfunction

	// cell memory: character byte over color attribute
	tcw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// handshake and request decode helpers
	assign req_ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept      = req_valid && req_ready;
	assign is_nl       = (req.char_code == CHAR_LF) || (req.char_code == CHAR_CR);
	assign at_row_end  = (cur_col_q == COL_W'(NUM_COLS - 1));
	assign at_last_row = (cur_row_q == ROW_W'(NUM_ROWS - 1));
	assign rd_in_range = ({1'b0, req.cell_row} < (ROW_W + 1)'(NUM_ROWS)) &&
		({1'b0, req.cell_col} < (COL_W + 1)'(NUM_COLS));
	assign color_step  = (color_q == COLOR_LAST) ? COLOR_FIRST : color_q + 4'd1;
	assign top_step    = (top_q == ROW_W'(NUM_ROWS - 1)) ? '0 : top_q + 5'd1;
	assign scroll_base = ADDR_W'(top_q) * COLS_A;
	assign ram_raddr   = cell_addr(req.cell_row, req.cell_col, top_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, cursor update, memory port and result word
	always_comb begin
		state_d      = state_q;
		cur_col_d    = cur_col_q;
		cur_row_d    = cur_row_q;
		color_d      = color_q;
		top_d        = top_q;
		sweep_addr_d = sweep_addr_q;
		sweep_last_d = sweep_last_q;
		ram_we       = 1'b0;
		ram_waddr    = cell_addr(cur_row_q, cur_col_q, top_q);
		ram_wdata    = {req.char_code, color_q};
		rsp_load     = 1'b0;
		rsp_next     = '0;

		unique case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_addr_q;
				ram_wdata = '0;
				if (sweep_addr_q == sweep_last_q) begin
					state_d = ST_IDLE;
				end else begin
					sweep_addr_d = sweep_addr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_PUT: begin
							rsp_load = 1'b1;
							ram_we   = !is_nl;
							if (is_nl || at_row_end) begin
								color_d   = color_step;
								cur_col_d = '0;
								if (at_last_row) begin
									// scroll: recycle the top row as the new bottom row
									top_d        = top_step;
									sweep_addr_d = scroll_base;
									sweep_last_d = scroll_base + ADDR_W'(NUM_COLS - 1);
									state_d      = ST_SWEEP;
								end else begin
									cur_row_d = cur_row_q + 5'd1;
								end
							end else begin
								cur_col_d = cur_col_q + 7'd1;
							end
						end
						REQ_READ: begin
							state_d = ST_RD_WAIT;
						end
						REQ_CLEAR: begin
							rsp_load     = 1'b1;
							cur_col_d    = '0;
							cur_row_d    = '0;
							top_d        = '0;
							sweep_addr_d = '0;
							sweep_last_d = ADDR_W'(CELLS - 1);
							state_d      = ST_SWEEP;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				rsp_load = 1'b1;
				state_d  = ST_IDLE;
				if (rd_ok_s1) begin
					rsp_next.cell_char = ram_rdata[DATA_W-1:ATTR_W];
					rsp_next.cell_attr = ram_rdata[ATTR_W-1:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_next.cursor_col    = cur_col_d;
		rsp_next.cursor_row    = cur_row_d;
		rsp_next.current_color = color_d;
	end

	// cursor, color, ring pointer and sweep range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			color_q      <= COLOR_FIRST;
			top_q        <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= ADDR_W'(CELLS - 1);
		end else begin
			cur_col_q    <= cur_col_d;
			cur_row_q    <= cur_row_d;
			color_q      <= color_d;
			top_q        <= top_d;
			sweep_addr_q <= sweep_addr_d;
			sweep_last_q <= sweep_last_d;
		end
	end

	// read range flag travels with the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= rd_in_range;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_data_q;

	// a read finds the result slot empty and no write in flight on its data cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_READ) |=> (state_q == ST_RD_WAIT && !rsp_valid_q))
		else $error("read data cycle found result slot busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_WAIT) |-> !ram_we)
		else $error("memory write during read data cycle");

	// cursor stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_row_q} < (ROW_W + 1)'(NUM_ROWS)) &&
		({1'b0, cur_col_q} < (COL_W + 1)'(NUM_COLS)))
		else $error("cursor left the screen");

	// sweep stays inside the memory and never passes its end address
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (sweep_addr_q <= sweep_last_q &&
		sweep_last_q <= ADDR_W'(CELLS - 1)))
		else $error("clearing sweep out of range");

	// color only ever moves within the cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(color_q != $past(color_q)) |->
		(color_q == COLOR_FIRST || color_q == $past(color_q) + 4'd1))
		else $error("color stepped outside its cycle");

endmodule

`default_nettype wire

>>> verif/text_console_writer_test.sv
// self-checking testbench for the text console writer: random and directed requests,
// with a predictor that mirrors the screen, cursor and color and checks every result word
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam int COLS = NUM_COLS_DEF;
	localparam int ROWS = NUM_ROWS_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 8000;
	localparam int MAX_PRINTED = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	tcw_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	tcw_rsp_t rsp;

	// stimulus and expectations
	tcw_req_t pending_req[$];
	tcw_rsp_t expected_rsp[$];

	// mirrored console state
	logic [CHAR_W-1:0] screen_char [ROWS][COLS];
	logic [ATTR_W-1:0] screen_attr [ROWS][COLS];
	logic [COL_W-1:0] pos_col;
	logic [ROW_W-1:0] pos_row;
	logic [ATTR_W-1:0] ink;

	// statistics
	int errors = 0;
	int n_put = 0, n_read = 0, n_clear = 0, n_unused = 0;
	int n_scroll = 0, n_line_end = 0, n_color_wrap = 0;
	int words_checked = 0;

	// handshake bookkeeping
	int req_sent = 0;
	int req_gap = 0;
	int rsp_taken = 0;
	int rsp_wait = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	tcw_rsp_t want;

	text_console_writer #(
		.NUM_COLS(COLS),
		.NUM_ROWS(ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_screen();
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				screen_char[r][c] = '0;
				screen_attr[r][c] = '0;
			end
		end
		pos_col = '0;
		pos_row = '0;
	endfunction

	// color step, then column home, and scroll when leaving the bottom row
	function automatic void start_new_line();
		if (ink == COLOR_LAST) begin
			ink = COLOR_FIRST;
			n_color_wrap++;
		end else begin
			ink = ink + 1'b1;
		end
		pos_col = '0;
		if (pos_row == ROWS - 1) begin
			for (int r = 0; r < ROWS - 1; r++) begin
				for (int c = 0; c < COLS; c++) begin
					screen_char[r][c] = screen_char[r + 1][c];
					screen_attr[r][c] = screen_attr[r + 1][c];
				end
			end
			for (int c = 0; c < COLS; c++) begin
				screen_char[ROWS - 1][c] = '0;
				screen_attr[ROWS - 1][c] = '0;
			end
			n_scroll++;
		end else begin
			pos_row = pos_row + 1'b1;
		end
	endfunction

	// apply one request to the mirror and return the word it should produce
	function automatic tcw_rsp_t console_step(input tcw_req_t rq);
		tcw_rsp_t o;
		o = '0;
		case (rq.req_type)
			REQ_PUT: begin
				n_put++;
				if (rq.char_code == CHAR_LF || rq.char_code == CHAR_CR) begin
					start_new_line();
				end else begin
					screen_char[pos_row][pos_col] = rq.char_code;
					screen_attr[pos_row][pos_col] = ink;
					if (pos_col == COLS - 1) begin
						n_line_end++;
						start_new_line();
					end else begin
						pos_col = pos_col + 1'b1;
					end
				end
			end
			REQ_READ: begin
				n_read++;
				if (rq.cell_row < ROWS && rq.cell_col < COLS) begin
					o.cell_char = screen_char[rq.cell_row][rq.cell_col];
					o.cell_attr = screen_attr[rq.cell_row][rq.cell_col];
				end
			end
			REQ_CLEAR: begin
				n_clear++;
				clear_screen();
			end
			default: n_unused++;
		endcase
		o.cursor_col = pos_col;
		o.cursor_row = pos_row;
		o.current_color = ink;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want_v);
	endtask

	task automatic add_item(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		tcw_req_t t;
		t.req_type = kind;
		t.char_code = ch;
		t.cell_row = row;
		t.cell_col = col;
		pending_req.push_back(t);
	endtask

	// put with random don't-care address fields
	task automatic add_put(input logic [CHAR_W-1:0] ch);
		add_item(REQ_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
	endtask

	// mostly printable text, now and then any byte
	function automatic logic [CHAR_W-1:0] text_byte();
		if ($urandom_range(0, 7) == 0)
			return CHAR_W'($urandom_range(0, 255));
		return CHAR_W'($urandom_range(32, 126));
	endfunction

	task automatic add_reads(input int count);
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		for (int i = 0; i < count; i++) begin
			row = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(0, 31))
				: ROW_W'($urandom_range(0, ROWS - 1));
			col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 127))
				: COL_W'($urandom_range(0, COLS - 1));
			add_item(REQ_READ, CHAR_W'($urandom_range(0, 255)), row, col);
		end
	endtask

	// request driver: holds each word until taken, random gap after each
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				req_sent++;
				req_gap = (((req_sent / 64) % 4) == 3) ? 0 : $urandom_range(0, 4);
			end
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_req.size() != 0) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: random stalls, plus two long hold-offs to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_taken++;
				rsp_wait = (((rsp_taken / 64) % 4) == 1) ? 0 : $urandom_range(0, 4);
				if (rsp_taken == 150 || rsp_taken == 450)
					hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rsp_wait > 0) begin
				rsp_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on each accepted request, check each accepted result word
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_rsp.push_back(console_step(req));
			if (rsp_valid && rsp_ready) begin
				words_checked++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("result word with nothing expected", rsp, '0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.cell_char !== want.cell_char)
						report_mismatch("cell_char", rsp.cell_char, want.cell_char);
					if (rsp.cell_attr !== want.cell_attr)
						report_mismatch("cell_attr", rsp.cell_attr, want.cell_attr);
					if (rsp.cursor_col !== want.cursor_col)
						report_mismatch("cursor_col", rsp.cursor_col, want.cursor_col);
					if (rsp.cursor_row !== want.cursor_row)
						report_mismatch("cursor_row", rsp.cursor_row, want.cursor_row);
					if (rsp.current_color !== want.current_color)
						report_mismatch("current_color", rsp.current_color,
							want.current_color);
				end
			end
		end
	end

	// watchdog on cycles with no word moving in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
					quiet_cycles, expected_rsp.size());
				$display("text_console_writer_test: done, errors");
				$finish;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int stop_at;
		int len;
		int seg_kind;

		clear_screen();
		ink = COLOR_FIRST;

		// directed: empty screen, extreme bytes, both line starts, corner and
		// out-of-screen reads, unused code, clear keeping the color
		add_item(REQ_READ, '0, '0, '0);
		add_item(REQ_PUT, 8'h00, '0, '0);
		add_item(REQ_PUT, 8'hFF, 5'h1F, 7'h7F);
		add_item(REQ_PUT, 8'h41, '0, '0);
		add_item(REQ_READ, '0, '0, 7'd1);
		add_item(REQ_PUT, CHAR_CR, '0, '0);
		add_item(REQ_PUT, 8'h55, '0, '0);
		add_item(REQ_PUT, CHAR_LF, '0, '0);
		add_item(REQ_READ, '0, 5'd1, '0);
		add_item(REQ_READ, '0, '0, 7'd2);
		add_item(REQ_READ, '0, ROW_W'(ROWS - 1), COL_W'(COLS - 1));
		add_item(REQ_READ, '0, ROW_W'(ROWS), '0);
		add_item(REQ_READ, '0, '0, COL_W'(COLS));
		add_item(REQ_READ, 8'hFF, 5'h1F, 7'h7F);
		add_item(REQ_UNUSED, 8'hFF, 5'h1F, 7'h7F);
		add_item(REQ_UNUSED, '0, '0, '0);
		add_item(REQ_CLEAR, 8'hA5, 5'h15, 7'h2A);
		add_item(REQ_READ, '0, '0, '0);
		add_item(REQ_READ, '0, 5'd1, '0);
		add_item(REQ_PUT, 8'hAA, '0, '0);
		add_item(REQ_PUT, 8'h7E, '0, '0);

		// random: text lines, full lines that run off the row, blank lines,
		// reads, noise and the odd clear
		stop_at = pending_req.size() + 750;
		while (pending_req.size() < stop_at) begin
			seg_kind = $urandom_range(0, 19);
			if (seg_kind <= 8) begin
				len = $urandom_range(0, 20);
				for (int i = 0; i < len; i++)
					add_put(text_byte());
				case ($urandom_range(0, 3))
					0: ;
					1: add_put(CHAR_CR);
					default: add_put(CHAR_LF);
				endcase
			end else if (seg_kind <= 10) begin
				len = $urandom_range(COLS - 2, COLS + 4);
				for (int i = 0; i < len; i++)
					add_put(text_byte());
			end else if (seg_kind <= 13) begin
				add_reads($urandom_range(1, 6));
			end else if (seg_kind <= 16) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					add_put($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
			end else if (seg_kind <= 18) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					add_item(($urandom_range(0, 3) != 0) ? REQ_UNUSED
						: 2'($urandom_range(0, 1)),
						CHAR_W'($urandom_range(0, 255)),
						ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
			end else if ($urandom_range(0, 2) == 0) begin
				add_item(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
					ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
			end else begin
				add_reads(2);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
		// a trailing clear or scroll may still be running
		repeat (2000) @(posedge clk);

		$display("requests: %0d put, %0d read, %0d clear, %0d unused; %0d result words checked",
			n_put, n_read, n_clear, n_unused, words_checked);
		$display("console events: %0d scrolls, %0d row-end wraps, %0d color wraps",
			n_scroll, n_line_end, n_color_wrap);
		if (errors == 0) begin
			$display("text_console_writer_test: done, clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("text_console_writer_test: done, errors");
		end
		$finish;
	end

endmodule
